>>> hw/rtl/multichannel_moving_average_filter_unit_defines.svh
// Assertion macros shared by the filter RTL. Both expect clk and rst in scope.
`ifndef MULTICHANNEL_MOVING_AVERAGE_FILTER_UNIT_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MAF_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("maf: assertion failed");
`define MAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("maf: assertion failed");
`else
`define MAF_ASSERT(lbl, ante, cons)
`define MAF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/maf_pkg.sv
`default_nettype none

package maf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CH_W     = 2;
  localparam int VALUE_W  = 14;
  localparam int QUOT_W   = 14;

  localparam logic KIND_SAMPLE    = 1'b0;
  localparam logic KIND_ROUND_END = 1'b1;

  localparam logic [CH_W-1:0] CH_TEMP  = 2'd0;
  localparam logic [CH_W-1:0] CH_PH    = 2'd1;
  localparam logic [CH_W-1:0] CH_LEVEL = 2'd2;
  localparam logic [CH_W-1:0] CH_TURB  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_READ,
    S_CONV
  } maf_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_FN,
    C_NUM,
    C_DEN,
    C_LO,
    C_HI,
    C_DIV,
    C_DONE
  } maf_conv_state_t;

  typedef struct packed {
    logic            start;
    logic            ack;
    logic [CH_W-1:0] ch;
  } maf_conv_cmd_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] value;
    logic               clamped;
  } maf_conv_rsp_t;

  // Output limits in hundredths of the unit
  function automatic logic [VALUE_W-1:0] chan_lo(input logic [CH_W-1:0] ch);
    logic [VALUE_W-1:0] r;
    unique case (ch)
      CH_TEMP:  r = 14'd1500;
      CH_PH:    r = 14'd400;
      CH_LEVEL: r = 14'd0;
      CH_TURB:  r = 14'd0;
      default:  r = 14'd0;
    endcase
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] chan_hi(input logic [CH_W-1:0] ch);
    logic [VALUE_W-1:0] r;
    unique case (ch)
      CH_TEMP:  r = 14'd3500;
      CH_PH:    r = 14'd1000;
      CH_LEVEL: r = 14'd10000;
      CH_TURB:  r = 14'd5000;
      default:  r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/maf_in_if.sv
`default_nettype none

interface maf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [maf_pkg::CH_W-1:0]     channel;
  logic [maf_pkg::SAMPLE_W-1:0] sample_code;

  modport source (output valid, output kind, output channel, output sample_code, input ready);
  modport sink   (input valid, input kind, input channel, input sample_code, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/maf_out_if.sv
`default_nettype none

interface maf_out_if;
  logic                        valid;
  logic                        ready;
  logic [maf_pkg::CH_W-1:0]    channel_out;
  logic [maf_pkg::VALUE_W-1:0] filtered_value;
  logic                        was_clamped;

  modport source (output valid, output channel_out, output filtered_value,
                  output was_clamped, input ready);
  modport sink   (input valid, input channel_out, input filtered_value,
                  input was_clamped, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/maf_ram.sv
`default_nettype none

module maf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 40,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/maf_conv.sv
`default_nettype none
`include "multichannel_moving_average_filter_unit_defines.svh"

// Linear conversion, clamp and rounded divide of one window sum.
// One limit multiplier and one subtractor, reused under a small sequencer.
module maf_conv #(
  parameter int WINDOW    = 10,
  parameter int CODE_BITS = 12,
  localparam int N_W   = $clog2(WINDOW + 1),
  localparam int SUM_W = maf_pkg::SAMPLE_W + N_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire maf_pkg::maf_conv_cmd_t cmd,
  input  wire logic [SUM_W-1:0]       sum,
  input  wire logic [N_W-1:0]         n,
  output maf_pkg::maf_conv_rsp_t      rsp
);

  localparam int FN_W = CODE_BITS + N_W;
  localparam int WIDE = FN_W + 17;
  localparam logic [FN_W-1:0] FS_EXT = FN_W'((1 << CODE_BITS) - 1);
  localparam logic [3:0] LAST_BIT = 4'(maf_pkg::QUOT_W - 1);

  maf_pkg::maf_conv_state_t state, state_next;

  logic [maf_pkg::CH_W-1:0]    ch_r;
  logic [SUM_W-1:0]            sum_r;
  logic [N_W-1:0]              n_r;
  logic [FN_W-1:0]             fn;
  logic signed [WIDE-1:0]      num;
  logic signed [WIDE-1:0]      den;
  logic [maf_pkg::VALUE_W-1:0] lo_r;
  logic [maf_pkg::VALUE_W-1:0] hi_r;
  logic                        lt_lo;
  logic signed [WIDE-1:0]      rem;
  logic signed [WIDE-1:0]      dsh;
  logic [3:0]                  bit_cnt;
  logic [maf_pkg::VALUE_W-1:0] value;
  logic                        clamped;

  logic signed [WIDE-1:0]      fn_s;
  logic signed [WIDE-1:0]      s_s;
  logic signed [WIDE-1:0]      num_calc;
  logic [maf_pkg::VALUE_W-1:0] lim;
  logic signed [WIDE-1:0]      lim_prod;
  logic signed [WIDE-1:0]      trial;

  always_comb begin
    fn_s = WIDE'(fn);
    s_s  = WIDE'(sum_r);
    unique case (ch_r)
      maf_pkg::CH_TEMP:  num_calc = WIDE'(25 * fn_s + 4950 * s_s);
      maf_pkg::CH_PH:    num_calc = WIDE'(4850 * fn_s - 5500 * s_s);
      maf_pkg::CH_LEVEL: num_calc = WIDE'(10000 * s_s);
      default:           num_calc = WIDE'(3300 * (fn_s - s_s));
    endcase
    // shared limit multiplier: lo*den, then hi*den
    lim      = (state == maf_pkg::C_LO) ? lo_r : hi_r;
    lim_prod = $signed({1'b0, lim}) * den;
    trial    = rem - dsh;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      maf_pkg::C_IDLE: if (cmd.start) state_next = maf_pkg::C_FN;
      maf_pkg::C_FN:   state_next = maf_pkg::C_NUM;
      maf_pkg::C_NUM:  state_next = maf_pkg::C_DEN;
      maf_pkg::C_DEN:  state_next = maf_pkg::C_LO;
      maf_pkg::C_LO:   state_next = maf_pkg::C_HI;
      maf_pkg::C_HI:
        state_next = (lt_lo || num > lim_prod) ? maf_pkg::C_DONE : maf_pkg::C_DIV;
      maf_pkg::C_DIV:  if (bit_cnt == '0) state_next = maf_pkg::C_DONE;
      maf_pkg::C_DONE: if (cmd.ack) state_next = maf_pkg::C_IDLE;
      default:         state_next = maf_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= maf_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      maf_pkg::C_IDLE: begin
        ch_r  <= cmd.ch;
        sum_r <= sum;
        n_r   <= n;
      end
      maf_pkg::C_FN:  fn  <= FS_EXT * FN_W'(n_r);
      maf_pkg::C_NUM: num <= num_calc;
      maf_pkg::C_DEN: begin
        den  <= (ch_r == maf_pkg::CH_PH) ? WIDE'(3 * fn_s) : fn_s;
        lo_r <= maf_pkg::chan_lo(ch_r);
        hi_r <= maf_pkg::chan_hi(ch_r);
      end
      maf_pkg::C_LO: lt_lo <= (num < lim_prod);
      maf_pkg::C_HI: begin
        if (lt_lo) begin
          value   <= lo_r;
          clamped <= 1'b1;
        end else if (num > lim_prod) begin
          value   <= hi_r;
          clamped <= 1'b1;
        end else begin
          // round half up: (2N + D) / (2D)
          value   <= '0;
          clamped <= 1'b0;
          rem     <= (num <<< 1) + den;
          dsh     <= den <<< (maf_pkg::QUOT_W);
          bit_cnt <= LAST_BIT;
        end
      end
      maf_pkg::C_DIV: begin
        value   <= {value[maf_pkg::VALUE_W-2:0], ~trial[WIDE-1]};
        if (!trial[WIDE-1]) rem <= trial;
        dsh     <= dsh >>> 1;
        bit_cnt <= bit_cnt - 4'd1;
      end
      maf_pkg::C_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    rsp.done    = (state == maf_pkg::C_DONE);
    rsp.value   = value;
    rsp.clamped = clamped;
  end

  `MAF_ASSERT(a_div_rem_bound, state == maf_pkg::C_DIV, rem >= 0 && rem < (dsh <<< 1))
  `MAF_ASSERT(a_value_in_range, rsp.done, rsp.value >= lo_r && rsp.value <= hi_r)
  `MAF_ASSERT_NEXT(a_done_holds, rsp.done && !cmd.ack, rsp.done)

endmodule

`default_nettype wire

>>> hw/rtl/multichannel_moving_average_filter_unit.sv
`default_nettype none
`include "multichannel_moving_average_filter_unit_defines.svh"

// Channel  Dir  Fields                                      Meaning
// item     in   kind, channel, sample_code                  ADC code or end of round
// result   out  channel_out, filtered_value, was_clamped    averaged value, 0.01 unit
//
// End-of-round transfer: no result. Sample transfer: the window is read one
// entry per cycle (n = window entries averaged), then the 14-step shared
// divider runs; a clamped result skips the divider.
// Reset: a clearing pass writes zero to all CHANNELS*WINDOW window entries,
// one per cycle; item.ready stays low until it ends.
// A finished result waits in the output register; the next transfer is
// taken while it waits, and only a second result stalls on result.ready.
module multichannel_moving_average_filter_unit #(
  parameter int WINDOW    = 10,
  parameter int CHANNELS  = 4,
  parameter int CODE_BITS = 12
) (
  input  wire logic  clk,
  input  wire logic  rst,
  maf_in_if.sink     item,
  maf_out_if.source  result
);

  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int N_W    = $clog2(WINDOW + 1);
  localparam int SUM_W  = maf_pkg::SAMPLE_W + N_W;
  localparam logic [maf_pkg::SAMPLE_W-1:0] CODE_MASK =
    (CODE_BITS >= maf_pkg::SAMPLE_W) ? {maf_pkg::SAMPLE_W{1'b1}}
                                     : maf_pkg::SAMPLE_W'((1 << CODE_BITS) - 1);

  maf_pkg::maf_state_t state, state_next;

  // control
  logic [ADDR_W-1:0] clr_addr;
  logic [IDX_W-1:0]  idx;
  logic              full;
  logic [N_W-1:0]    rd_cnt;
  logic              rd_pend;
  logic              out_valid;

  // payload
  logic [maf_pkg::CH_W-1:0]     ch_r;
  logic [maf_pkg::SAMPLE_W-1:0] code_r;
  logic [ADDR_W-1:0]            base;
  logic [N_W-1:0]               n_r;
  logic [SUM_W-1:0]             sum;
  logic [maf_pkg::CH_W-1:0]     out_ch;
  logic [maf_pkg::VALUE_W-1:0]  out_val;
  logic                         out_clamp;

  // window memory port
  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [maf_pkg::SAMPLE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]            ram_raddr;
  logic [maf_pkg::SAMPLE_W-1:0] ram_rdata;

  maf_pkg::maf_conv_cmd_t conv_cmd;
  maf_pkg::maf_conv_rsp_t conv_rsp;

  logic take;
  logic sample_ok;
  logic rd_issue;
  logic rd_done;
  logic load_ok;

  always_comb begin
    take      = item.valid && item.ready;
    sample_ok = (item.kind == maf_pkg::KIND_SAMPLE) && (32'(item.channel) < CHANNELS);
    rd_issue  = (state == maf_pkg::S_READ) && (rd_cnt != n_r);
    rd_done   = (state == maf_pkg::S_READ) && (rd_cnt == n_r) && !rd_pend;
    load_ok   = (state == maf_pkg::S_CONV) && conv_rsp.done && (!out_valid || result.ready);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      maf_pkg::S_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = maf_pkg::S_IDLE;
      maf_pkg::S_IDLE:  if (take && sample_ok) state_next = maf_pkg::S_WRITE;
      maf_pkg::S_WRITE: state_next = maf_pkg::S_READ;
      maf_pkg::S_READ:  if (rd_done) state_next = maf_pkg::S_CONV;
      maf_pkg::S_CONV:  if (load_ok) state_next = maf_pkg::S_IDLE;
      default:          state_next = maf_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item.ready   = (state == maf_pkg::S_IDLE);
    ram_we       = (state == maf_pkg::S_CLEAR) || (state == maf_pkg::S_WRITE);
    ram_waddr    = (state == maf_pkg::S_CLEAR) ? clr_addr : base + ADDR_W'(idx);
    ram_wdata    = (state == maf_pkg::S_CLEAR) ? '0 : code_r;
    ram_raddr    = base + ADDR_W'(rd_cnt[IDX_W-1:0]);
    conv_cmd.start = rd_done;
    conv_cmd.ack   = load_ok;
    conv_cmd.ch    = ch_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= maf_pkg::S_CLEAR;
      clr_addr  <= '0;
      idx       <= '0;
      full      <= 1'b0;
      rd_cnt    <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_issue;
      if (state == maf_pkg::S_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
      // end of round: shared index wraps and marks the window full
      if (take && item.kind == maf_pkg::KIND_ROUND_END) begin
        if (idx == IDX_W'(WINDOW - 1)) begin
          idx  <= '0;
          full <= 1'b1;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
      if (take) rd_cnt <= '0;
      else if (rd_issue) rd_cnt <= rd_cnt + N_W'(1);
      if (load_ok) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ch_r   <= item.channel;
      code_r <= item.sample_code & CODE_MASK;
      base   <= ADDR_W'(32'(item.channel) * WINDOW);
      n_r    <= full ? N_W'(WINDOW) : N_W'(idx) + N_W'(1);
      sum    <= '0;
    end else if (rd_pend) begin
      sum <= sum + SUM_W'(ram_rdata);
    end
    if (load_ok) begin
      out_ch    <= ch_r;
      out_val   <= conv_rsp.value;
      out_clamp <= conv_rsp.clamped;
    end
  end

  always_comb begin
    result.valid          = out_valid;
    result.channel_out    = out_ch;
    result.filtered_value = out_val;
    result.was_clamped    = out_clamp;
  end

  maf_ram #(
    .WIDTH (maf_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  maf_conv #(
    .WINDOW    (WINDOW),
    .CODE_BITS (CODE_BITS)
  ) u_conv (
    .clk (clk),
    .rst (rst),
    .cmd (conv_cmd),
    .sum (sum),
    .n   (n_r),
    .rsp (conv_rsp)
  );

  `MAF_ASSERT(a_waddr_range, ram_we, 32'(ram_waddr) < DEPTH)
  `MAF_ASSERT(a_rd_cnt_bound, state == maf_pkg::S_READ, rd_cnt <= n_r && n_r != '0)
  `MAF_ASSERT(a_idx_range, 1'b1, 32'(idx) < WINDOW)
  `MAF_ASSERT(a_conv_owned, conv_rsp.done, state == maf_pkg::S_CONV)

endmodule

`default_nettype wire

>>> tb/tb_multichannel_moving_average_filter_unit.sv
module tb_multichannel_moving_average_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W     = maf_pkg::CH_W;
  localparam int SAMPLE_W = maf_pkg::SAMPLE_W;
  localparam int VALUE_W  = maf_pkg::VALUE_W;

  localparam logic KIND_SAMPLE    = maf_pkg::KIND_SAMPLE;
  localparam logic KIND_ROUND_END = maf_pkg::KIND_ROUND_END;

  localparam logic [CH_W-1:0] CH_TEMP  = maf_pkg::CH_TEMP;
  localparam logic [CH_W-1:0] CH_PH    = maf_pkg::CH_PH;
  localparam logic [CH_W-1:0] CH_LEVEL = maf_pkg::CH_LEVEL;
  localparam logic [CH_W-1:0] CH_TURB  = maf_pkg::CH_TURB;

  // Block configuration, kept equal to the DUT parameters below.
  localparam int WIN        = 10;
  localparam int NCH        = 4;
  localparam int CODE_W     = 12;
  localparam longint FULL_SCALE = (longint'(1) << CODE_W) - 1;

  // Run shape.
  localparam int ITEMS_PER_PHASE = 340;  // five random phases
  localparam int HOLD_OFF_CYCLES = 300;  // long receiver hold-off in the pressure phase
  localparam int OPEN_CYCLES     = 80;   // receiver open stretch between hold-offs
  localparam int DRAIN_CYCLES    = 64;   // idle time after the drain to catch any extra result
  localparam int WATCHDOG_LIMIT  = 3000; // cycles without any transfer

  typedef enum int {
    PH_FREE,
    PH_SEND_GAP,
    PH_RECV_STALL,
    PH_BOTH,
    PH_PRESSURE
  } traffic_mode_t;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [VALUE_W-1:0] value;
    logic               clamped;
  } filt_result_t;

  // One row of the directed table. Rows with has_value set carry the result
  // typed in by hand; the others are checked against the predictor.
  typedef struct packed {
    logic                kind;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] code;
    logic                has_value;
    logic [VALUE_W-1:0]  value;
    logic                clamped;
  } stim_row_t;

  localparam int N_DIRECTED = 24;

  logic clk = 1'b0;
  logic rst;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  maf_in_if  item_ch ();
  maf_out_if result_ch ();

  multichannel_moving_average_filter_unit #(
    .WINDOW    (WIN),
    .CHANNELS  (NCH),
    .CODE_BITS (CODE_W)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the per-channel windows, the shared write
  // index and the wrapped flag.
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] win_codes [NCH*WIN];
  int                  wr_idx;
  bit                  wrapped;

  filt_result_t  pending_results [$];
  traffic_mode_t traffic_mode = PH_FREE;

  int mismatches     = 0;
  int results_seen   = 0;
  int clamped_seen   = 0;
  int samples_sent   = 0;
  int round_ends     = 0;
  int window_wraps   = 0;
  int long_holds     = 0;

  function automatic void clear_windows();
    for (int i = 0; i < NCH*WIN; i++) win_codes[i] = '0;
    wr_idx  = 0;
    wrapped = 1'b0;
  endfunction

  // Updates the windows for one accepted transfer; returns 1 when the
  // transfer yields a filtered value.
  function automatic bit filter_update(input logic kind, input logic [CH_W-1:0] ch,
                                       input logic [SAMPLE_W-1:0] code,
                                       output filt_result_t res);
    longint sum, cnt, fn, num, den, lo, hi;
    int     base;
    res = '0;
    if (kind == KIND_ROUND_END) begin
      if (wr_idx + 1 >= WIN) begin
        wr_idx  = 0;
        wrapped = 1'b1;
        window_wraps++;
      end else begin
        wr_idx = wr_idx + 1;
      end
      return 1'b0;
    end
    if (int'(ch) >= NCH) return 1'b0;
    base = int'(ch) * WIN;
    win_codes[base + wr_idx] = code;
    cnt = wrapped ? WIN : wr_idx + 1;
    sum = 0;
    for (int i = 0; i < cnt; i++) sum += longint'(win_codes[base + i]);
    fn = FULL_SCALE * cnt;
    // Average of codes first, then each channel's linear law, kept as N / D.
    case (ch)
      CH_TEMP: begin
        num = 25 * fn + 4950 * sum;   den = fn;     lo = 1500; hi = 3500;
      end
      CH_PH: begin
        num = 4850 * fn - 5500 * sum; den = 3 * fn; lo = 400;  hi = 1000;
      end
      CH_LEVEL: begin
        num = 10000 * sum;            den = fn;     lo = 0;    hi = 10000;
      end
      default: begin
        num = 3300 * (fn - sum);      den = fn;     lo = 0;    hi = 5000;
      end
    endcase
    res.ch = ch;
    if (num < lo * den) begin
      res.value   = VALUE_W'(lo);
      res.clamped = 1'b1;
    end else if (num > hi * den) begin
      res.value   = VALUE_W'(hi);
      res.clamped = 1'b1;
    end else begin
      // Nearest integer, halves up; a value right on a limit is not flagged.
      res.value   = VALUE_W'((2 * num + den) / (2 * den));
      res.clamped = 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Traffic shaping
  // ---------------------------------------------------------------------------
  function automatic bit sender_idles();
    case (traffic_mode)
      PH_SEND_GAP: return $urandom_range(99) < 70;
      PH_BOTH:     return $urandom_range(99) < 28;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stalls();
    case (traffic_mode)
      PH_RECV_STALL: return $urandom_range(99) < 70;
      PH_BOTH:       return $urandom_range(99) < 28;
      PH_PRESSURE:   return $urandom_range(99) < 50;
      default:       return 1'b0;
    endcase
  endfunction

  // Mostly uniform codes, with the code extremes now and then; the uniform part
  // also lands inside every channel's unclamped band.
  function automatic logic [SAMPLE_W-1:0] pick_code();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range(4095));
    endcase
  endfunction

  // Offers one item and holds it until the transfer. Called in the step of a
  // rising edge; returns in the step of the edge that took the transfer.
  task automatic send_item(input logic kind, input logic [CH_W-1:0] ch,
                           input logic [SAMPLE_W-1:0] code, input logic has_value = 1'b0,
                           input logic [VALUE_W-1:0] value = '0,
                           input logic clamped = 1'b0);
    filt_result_t want;
    while (sender_idles()) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.kind        <= kind;
    item_ch.channel     <= ch;
    item_ch.sample_code <= code;
    do @(posedge clk); while (!item_ch.ready);
    if (kind == KIND_ROUND_END) round_ends++;
    else samples_sent++;
    if (filter_update(kind, ch, code, want)) begin
      if (has_value) begin
        want.value   = value;
        want.clamped = clamped;
      end
      pending_results.push_back(want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern per phase, with long hold-offs under pressure
  // so the output register fills and the item channel backs up.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int open_left;
    open_left = 0;
    forever begin
      if (traffic_mode == PH_PRESSURE && open_left == 0) begin
        repeat (HOLD_OFF_CYCLES) begin
          result_ch.ready <= 1'b0;
          @(posedge clk);
        end
        long_holds++;
        open_left = OPEN_CYCLES;
      end
      if (open_left > 0) open_left--;
      result_ch.ready <= !sink_stalls();
      @(posedge clk);
    end
  end

  // Scoreboard: every result transfer against the oldest expected value.
  filt_result_t want_now;

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (result_ch.was_clamped) clamped_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: channel_out %0d filtered_value %0d",
               result_ch.channel_out, result_ch.filtered_value);
        mismatches++;
      end else begin
        want_now = pending_results.pop_front();
        if (result_ch.channel_out !== want_now.ch) begin
          $error("channel_out: expected %0d, got %0d", want_now.ch, result_ch.channel_out);
          mismatches++;
        end
        if (result_ch.filtered_value !== want_now.value) begin
          $error("filtered_value: expected %0d, got %0d",
                 want_now.value, result_ch.filtered_value);
          mismatches++;
        end
        if (result_ch.was_clamped !== want_now.clamped) begin
          $error("was_clamped: expected %0d, got %0d",
                 want_now.clamped, result_ch.was_clamped);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transfer for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_results.size());
    $display("tb_multichannel_moving_average_filter_unit: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [N_DIRECTED];

  initial begin : stimulus
    int            phase_items;
    int            first_ch;
    traffic_mode_t m;

    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.kind        = KIND_SAMPLE;
    item_ch.channel     = '0;
    item_ch.sample_code = '0;
    clear_windows();

    // Just after reset every window is empty and the index is zero, so each
    // sample averages only itself: those rows carry typed-in results.
    directed_rows = '{
      '{KIND_SAMPLE,    CH_TEMP,  12'd0,    1'b1, 14'd1500,  1'b1}, // below range
      '{KIND_SAMPLE,    CH_PH,    12'd0,    1'b1, 14'd1000,  1'b1}, // above range
      '{KIND_SAMPLE,    CH_LEVEL, 12'd0,    1'b1, 14'd0,     1'b0}, // on lower limit
      '{KIND_SAMPLE,    CH_TURB,  12'd0,    1'b1, 14'd3300,  1'b0},
      '{KIND_SAMPLE,    CH_TEMP,  12'd4095, 1'b1, 14'd3500,  1'b1}, // above range
      '{KIND_SAMPLE,    CH_PH,    12'd4095, 1'b1, 14'd400,   1'b1}, // below range
      '{KIND_SAMPLE,    CH_LEVEL, 12'd4095, 1'b1, 14'd10000, 1'b0}, // on upper limit
      '{KIND_SAMPLE,    CH_TURB,  12'd4095, 1'b1, 14'd0,     1'b0}, // on lower limit
      // end of round: channel and code are don't-care
      '{KIND_ROUND_END, CH_TURB,  12'd4095, 1'b0, 14'd0,     1'b0},
      '{KIND_SAMPLE,    CH_TEMP,  12'd2048, 1'b0, 14'd0,     1'b0}, // two-entry warm-up
      '{KIND_SAMPLE,    CH_PH,    12'd1365, 1'b0, 14'd0,     1'b0},
      '{KIND_SAMPLE,    CH_LEVEL, 12'd2730, 1'b0, 14'd0,     1'b0},
      '{KIND_SAMPLE,    CH_TURB,  12'd1,    1'b0, 14'd0,     1'b0},
      // nine more ends of round take the index through the wrap
      '{KIND_ROUND_END, CH_TEMP,  12'd0,    1'b0, 14'd0,     1'b0},
      '{KIND_ROUND_END, CH_PH,    12'd2730, 1'b0, 14'd0,     1'b0},
      '{KIND_ROUND_END, CH_LEVEL, 12'd1365, 1'b0, 14'd0,     1'b0},
      '{KIND_ROUND_END, CH_TURB,  12'd4095, 1'b0, 14'd0,     1'b0},
      '{KIND_ROUND_END, CH_TEMP,  12'd1,    1'b0, 14'd0,     1'b0},
      '{KIND_ROUND_END, CH_PH,    12'd2048, 1'b0, 14'd0,     1'b0},
      '{KIND_ROUND_END, CH_LEVEL, 12'd0,    1'b0, 14'd0,     1'b0},
      '{KIND_ROUND_END, CH_TURB,  12'd4094, 1'b0, 14'd0,     1'b0},
      '{KIND_ROUND_END, CH_TEMP,  12'd4095, 1'b0, 14'd0,     1'b0}, // wrap: window full
      '{KIND_SAMPLE,    CH_TEMP,  12'd2457, 1'b0, 14'd0,     1'b0}, // full-window average
      '{KIND_SAMPLE,    CH_LEVEL, 12'd4095, 1'b0, 14'd0,     1'b0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    traffic_mode = PH_FREE;
    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].ch, directed_rows[i].code,
                directed_rows[i].has_value, directed_rows[i].value,
                directed_rows[i].clamped);

    // Random part: mostly whole sensor rounds (four samples, then end of
    // round) with random codes; the rest is loose items and broken rounds.
    for (int p = 0; p < 5; p++) begin
      m = traffic_mode_t'(p);
      traffic_mode = m;
      phase_items  = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 80) begin
          first_ch = $urandom_range(3);
          for (int c = 0; c < NCH; c++) begin
            send_item(KIND_SAMPLE, CH_W'(first_ch + c), pick_code());
            phase_items++;
          end
          // now and then a round is left without its end
          if ($urandom_range(9) != 0) begin
            send_item(KIND_ROUND_END, CH_W'($urandom_range(3)), pick_code());
            phase_items++;
          end
        end else begin
          send_item(($urandom_range(1) != 0) ? KIND_ROUND_END : KIND_SAMPLE,
                    CH_W'($urandom_range(3)), pick_code());
          phase_items++;
        end
      end
    end
    item_ch.valid <= 1'b0;
    traffic_mode = PH_FREE;

    // Drain, then give the block time to show any extra result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples and %0d round ends, %0d window wraps, %0d long hold-offs",
             samples_sent, round_ends, window_wraps, long_holds);
    $display("checked %0d filtered values, %0d of them clamped, %0d mismatches",
             results_seen, clamped_seen, mismatches);
    if (mismatches == 0)
      $display("tb_multichannel_moving_average_filter_unit: PASS");
    else
      $display("tb_multichannel_moving_average_filter_unit: FAIL");
    $finish;
  end

endmodule
